[hw/rtl/dcacc_pkg.sv]
// Shared types and constants for the duty-cycle accumulator.
`timescale 1ns / 1ps
`default_nettype none

package dcacc_pkg;

  // Default widths of the time base, channel start times and cpu nesting count.
  localparam int TIME_WIDTH_DEF  = 64;
  localparam int START_WIDTH_DEF = 32;
  localparam int NEST_WIDTH_DEF  = 16;

  // Fixed field widths.
  localparam int TS_WIDTH    = 64;
  localparam int SUM_WIDTH   = 64;
  localparam int DUTY_WIDTH  = 16;
  localparam int DEPTH_WIDTH = 16;
  localparam int CH_WIDTH    = 2;
  localparam int NUM_CH      = 4;

  // Scale to hundredths of a percent.
  localparam int               SCALE_WIDTH = 14;
  localparam logic [13:0]      DC_SCALE    = 14'd10000;
  localparam int               NUM_WIDTH   = SUM_WIDTH + SCALE_WIDTH;

  // Quotient bits produced by the divider and its step counter width.
  localparam int Q_WIDTH    = DUTY_WIDTH;
  localparam int QCNT_WIDTH = $clog2(Q_WIDTH);

  typedef enum logic [1:0] {
    MODE_ON    = 2'd0,
    MODE_OFF   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  localparam logic [CH_WIDTH-1:0] CH_CPU      = 2'd0;
  localparam logic [CH_WIDTH-1:0] CH_RADIO    = 2'd1;
  localparam logic [CH_WIDTH-1:0] CH_RADIO_TX = 2'd2;
  localparam logic [CH_WIDTH-1:0] CH_RADIO_RX = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the input word
    logic exec;      // apply the event to the channel state
    logic mul;       // form sum * scale
    logic cmp;       // check saturation, seed the divider
    logic div_step;  // one restoring division step
    logic emit;      // write the result word
  } dcacc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic query_go;  // query with nonzero time since reset
    logic sat;       // quotient does not fit in the result width
    logic out_free;  // output register can take a word this cycle
  } dcacc_status_t;

endpackage

`default_nettype wire

[hw/rtl/dcacc_dp.sv]
// Datapath: channel state, scale multiplier, serial divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module dcacc_dp #(
  parameter int TIME_WIDTH  = dcacc_pkg::TIME_WIDTH_DEF,
  parameter int START_WIDTH = dcacc_pkg::START_WIDTH_DEF,
  parameter int NEST_WIDTH  = dcacc_pkg::NEST_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire dcacc_pkg::dcacc_cmd_t                cmd,
  output      dcacc_pkg::dcacc_status_t             status,
  input  wire logic [1:0]                           mode,
  input  wire logic [dcacc_pkg::CH_WIDTH-1:0]       channel,
  input  wire logic [dcacc_pkg::TS_WIDTH-1:0]       timestamp,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic [dcacc_pkg::DUTY_WIDTH-1:0]     duty_cycle,
  output      logic [dcacc_pkg::DEPTH_WIDTH-1:0]    cpu_depth
);

  localparam int TW   = TIME_WIDTH;
  localparam int SW   = START_WIDTH;
  localparam int QW   = dcacc_pkg::Q_WIDTH;
  localparam int NUMW = dcacc_pkg::NUM_WIDTH;
  localparam int CMPW = (NUMW > TW + QW) ? NUMW : TW + QW;

  // Latched event.
  dcacc_pkg::mode_t                mode_q;
  logic [dcacc_pkg::CH_WIDTH-1:0]  chan_q;
  logic [TW-1:0]                   ts_q;

  // Channel state.
  logic [SW-1:0]                   start_times [dcacc_pkg::NUM_CH];
  logic [dcacc_pkg::SUM_WIDTH-1:0] active_sums [dcacc_pkg::NUM_CH];
  logic [NEST_WIDTH-1:0]           nest_count;
  logic [TW-1:0]                   reset_time;

  // Query work registers.
  logic [TW-1:0]                   den;
  logic [NUMW-1:0]                 prod;
  logic [TW-1:0]                   rem;
  logic [QW-1:0]                   pbits;
  logic [QW-1:0]                   quo;
  logic                            go_q;
  logic                            sat_q;

  logic [dcacc_pkg::TS_WIDTH-1:0]  ts_ext;
  logic [SW-1:0]                   tstart;
  logic [SW-1:0]                   elapsed;
  logic [dcacc_pkg::SUM_WIDTH-1:0] elapsed_ext;
  logic [TW-1:0]                   den_now;
  logic [CMPW-1:0]                 prod_ext;
  logic [CMPW-1:0]                 den_shift;
  logic [TW:0]                     rem_x;
  logic [TW:0]                     rem_diff;
  logic                            take;

  assign ts_ext      = dcacc_pkg::TS_WIDTH'(ts_q);
  assign tstart      = ts_ext[SW-1:0];
  assign elapsed     = tstart - start_times[chan_q];
  assign elapsed_ext = dcacc_pkg::SUM_WIDTH'(elapsed);
  assign den_now     = ts_q - reset_time;

  assign prod_ext  = CMPW'(prod);
  assign den_shift = CMPW'(den) << QW;
  assign rem_x     = {rem, pbits[QW-1]};
  assign rem_diff  = rem_x - {1'b0, den};
  assign take      = rem_x >= {1'b0, den};

  assign status.query_go = (mode_q == dcacc_pkg::MODE_QUERY) && (den_now != '0);
  assign status.sat      = prod_ext >= den_shift;
  assign status.out_free = !out_valid || !out_stall;

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= dcacc_pkg::mode_t'(mode);
      chan_q <= channel;
      ts_q   <= timestamp[TW-1:0];
    end
  end

  // Channel state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dcacc_pkg::NUM_CH; i++) begin
        start_times[i] <= '0;
        active_sums[i] <= '0;
      end
      nest_count <= '0;
      reset_time <= '0;
    end else if (cmd.exec) begin
      unique case (mode_q)
        dcacc_pkg::MODE_ON: begin
          if (chan_q == dcacc_pkg::CH_CPU) begin
            if (nest_count == '0) begin
              start_times[chan_q] <= tstart;
            end
            nest_count <= nest_count + 1'b1;
          end else begin
            start_times[chan_q] <= tstart;
          end
        end
        dcacc_pkg::MODE_OFF: begin
          if (chan_q == dcacc_pkg::CH_CPU) begin
            if (nest_count == NEST_WIDTH'(1)) begin
              active_sums[chan_q] <= active_sums[chan_q] + elapsed_ext;
            end
            if (nest_count != '0) begin
              nest_count <= nest_count - 1'b1;
            end
          end else if (start_times[chan_q] != '0) begin
            active_sums[chan_q] <= active_sums[chan_q] + elapsed_ext;
            start_times[chan_q] <= '0;
          end
        end
        dcacc_pkg::MODE_QUERY: begin
        end
        dcacc_pkg::MODE_CLEAR: begin
          for (int i = 0; i < dcacc_pkg::NUM_CH; i++) begin
            active_sums[i] <= '0;
          end
          nest_count <= '0;
          reset_time <= ts_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Scale, saturation check and restoring division.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      den  <= den_now;
      go_q <= status.query_go;
    end
    if (cmd.mul) begin
      prod <= NUMW'(active_sums[chan_q]) * NUMW'(dcacc_pkg::DC_SCALE);
    end
    if (cmd.cmp) begin
      sat_q <= status.sat;
      rem   <= prod_ext[QW +: TW];
      pbits <= prod[QW-1:0];
      quo   <= '0;
    end
    if (cmd.div_step) begin
      if (take) begin
        rem <= rem_diff[TW-1:0];
      end else begin
        rem <= rem_x[TW-1:0];
      end
      pbits <= pbits << 1;
      quo   <= {quo[QW-2:0], take};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (!go_q) begin
        duty_cycle <= '0;
      end else if (sat_q) begin
        duty_cycle <= '1;
      end else begin
        duty_cycle <= quo;
      end
      cpu_depth <= dcacc_pkg::DEPTH_WIDTH'(nest_count);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dcacc_ctrl.sv]
// Controller: sequences capture, update, scale, division and result write.
`timescale 1ns / 1ps
`default_nettype none

module dcacc_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire dcacc_pkg::dcacc_status_t status,
  output      dcacc_pkg::dcacc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_CMP,
    S_DIV,
    S_FIN
  } state_t;

  state_t                           state;
  logic [dcacc_pkg::QCNT_WIDTH-1:0] cnt;
  logic                             last_step;

  assign last_step = cnt == dcacc_pkg::QCNT_WIDTH'(dcacc_pkg::Q_WIDTH - 1);

  assign in_stall     = state != S_IDLE;
  assign cmd.load     = (state == S_IDLE) && in_valid;
  assign cmd.exec     = state == S_EXEC;
  assign cmd.mul      = state == S_MUL;
  assign cmd.cmp      = state == S_CMP;
  assign cmd.div_step = state == S_DIV;
  assign cmd.emit     = (state == S_FIN) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= status.query_go ? S_MUL : S_FIN;
        end
        S_MUL: begin
          state <= S_CMP;
        end
        S_CMP: begin
          cnt   <= '0;
          state <= status.sat ? S_FIN : S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/duty_cycle_accumulator.sv]
// Top level of the duty-cycle accumulator: controller plus datapath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  mode, channel, timestamp
//   output   out        out_valid/out_stall  duty_cycle, cpu_depth
//
// An on, off or reset word passes through capture, update and the result
// write before the next input word is accepted. A query with time since reset
// runs the capture, one update, the 64 x 14 scale multiply, one saturation
// compare, then 16 restoring division steps, one quotient bit each, and
// then the result write. A saturating or zero-time query skips the divider.
// Reset (rst, synchronous) clears sums, start times, nesting count and the
// reset time, and empties the output register.
// The output register lets the next word be accepted while a result is
// held under out_stall; a second result waits in the controller until the
// register frees up.
`timescale 1ns / 1ps
`default_nettype none

module duty_cycle_accumulator #(
  parameter int TIME_WIDTH  = dcacc_pkg::TIME_WIDTH_DEF,
  parameter int START_WIDTH = dcacc_pkg::START_WIDTH_DEF,
  parameter int NEST_WIDTH  = dcacc_pkg::NEST_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [1:0]                        mode,
  input  wire logic [dcacc_pkg::CH_WIDTH-1:0]    channel,
  input  wire logic [dcacc_pkg::TS_WIDTH-1:0]    timestamp,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [dcacc_pkg::DUTY_WIDTH-1:0]  duty_cycle,
  output      logic [dcacc_pkg::DEPTH_WIDTH-1:0] cpu_depth
);

  dcacc_pkg::dcacc_cmd_t    cmd;
  dcacc_pkg::dcacc_status_t status;

  // Sequence each word: capture, update, and for queries scale and divide.
  dcacc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold channel state, run the query arithmetic, drive the result word.
  dcacc_dp #(
    .TIME_WIDTH  (TIME_WIDTH),
    .START_WIDTH (START_WIDTH),
    .NEST_WIDTH  (NEST_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (mode),
    .channel    (channel),
    .timestamp  (timestamp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .duty_cycle (duty_cycle),
    .cpu_depth  (cpu_depth)
  );

endmodule

`default_nettype wire
